/* rtl/arp_pkg.sv */
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, sizes and character codes for the AT response parser.
// ----------------------------------------------------------------------------
package arp_pkg;

    // text store geometry
    localparam int MAX_LINES   = 8;
    localparam int LINE_SIZE   = 64;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 6;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int LINE_W      = 4;
    localparam int COLIDX_W    = 7;
    localparam int STORE_DEPTH = MAX_LINES * LINE_SIZE;
    localparam int BYTE_W      = 8;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] UPPER_LO = 8'd65;
    localparam logic [7:0] UPPER_HI = 8'd90;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam logic [7:0] RAW_LO   = 8'd48;
    localparam logic [7:0] RAW_HI   = 8'd122;

    // action codes
    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // mode codes
    localparam logic MODE_INFO = 1'b0;
    localparam logic MODE_RAW  = 1'b1;

    // result status
    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_DONE   = 2'd1,
        ST_SYNTAX = 2'd2
    } arp_status_t;

    // parser states
    typedef enum logic [4:0] {
        S_WAIT_CR   = 5'd0,
        S_LF        = 5'd1,
        S_START     = 5'd2,
        S_OK_K      = 5'd3,
        S_FIN_CR    = 5'd4,
        S_FIN_LF    = 5'd5,
        S_ERR_R1    = 5'd7,
        S_ERR_R2    = 5'd8,
        S_ERR_O     = 5'd9,
        S_ERR_R3    = 5'd10,
        S_FINAL     = 5'd11,
        S_NAME1     = 5'd12,
        S_NAME      = 5'd13,
        S_SPACE     = 5'd14,
        S_TEXT1     = 5'd15,
        S_TEXT      = 5'd16,
        S_INFO_LF   = 5'd17,
        S_NEXT      = 5'd18,
        S_BLANK_LF  = 5'd19,
        S_RAW       = 5'd20,
        S_RAW_LF    = 5'd21,
        S_RAW_CR2   = 5'd22,
        S_RAW_LF2   = 5'd23,
        S_RAW_FINAL = 5'd24
    } arp_state_t;

    // store write request from the parser
    typedef struct packed {
        logic              we;
        logic              clear;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] data;
    } arp_wr_t;

    // parser view after one byte
    typedef struct packed {
        arp_status_t       status;
        logic              ok_mark;
        logic [LINE_W-1:0] lines;
    } arp_view_t;

endpackage

/* rtl/arp_ram.sv */
// ----------------------------------------------------------------------------
// arp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/arp_parser.sv */
// ----------------------------------------------------------------------------
// arp_parser
// Response syntax state machine with line and column position tracking.
// ----------------------------------------------------------------------------
module arp_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  logic                   mode,
    output arp_pkg::arp_view_t     view,
    output arp_pkg::arp_wr_t       wr
);

    arp_pkg::arp_state_t               state_reg, state_next;
    logic                              ok_reg, ok_next;
    logic [arp_pkg::LINE_W-1:0]        line_reg, line_next;
    logic [arp_pkg::COLIDX_W-1:0]      col_reg, col_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arp_pkg::S_WAIT_CR;
            ok_reg    <= 1'b0;
            line_reg  <= '0;
            col_reg   <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    // next state, store writes and status
    always_comb
    begin
        logic room;
        logic is_upper;
        logic is_print;
        logic is_raw;
        logic info_mode;
        logic do_put;
        logic do_end;
        logic do_plus;
        logic do_clear;
        arp_pkg::arp_status_t status;

        room      = (col_reg < arp_pkg::COLIDX_W'(arp_pkg::LINE_SIZE))
                    && (line_reg < arp_pkg::LINE_W'(arp_pkg::MAX_LINES));
        is_upper  = (rx_byte >= arp_pkg::UPPER_LO) && (rx_byte <= arp_pkg::UPPER_HI);
        is_print  = (rx_byte >= arp_pkg::PRINT_LO) && (rx_byte <= arp_pkg::PRINT_HI);
        is_raw    = (rx_byte >= arp_pkg::RAW_LO) && (rx_byte <= arp_pkg::RAW_HI);
        info_mode = (mode == arp_pkg::MODE_INFO);
        do_put    = 1'b0;
        do_end    = 1'b0;
        do_plus   = 1'b0;
        do_clear  = 1'b0;
        status    = arp_pkg::ST_BUSY;
        state_next = state_reg;
        ok_next    = ok_reg;
        line_next  = line_reg;
        col_next   = col_reg;

        unique case (state_reg) inside
            arp_pkg::S_WAIT_CR:
            begin
                if (rx_byte == arp_pkg::CH_CR)
                begin
                    state_next = arp_pkg::S_LF;
                    do_clear   = 1'b1;
                end
            end
            arp_pkg::S_LF:
            begin
                if (rx_byte == arp_pkg::CH_LF) state_next = arp_pkg::S_START;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_START:
            begin
                if (rx_byte == arp_pkg::CH_PLUS && info_mode)
                begin
                    state_next = arp_pkg::S_NAME1;
                    do_put     = 1'b1;
                end
                else if (rx_byte == arp_pkg::CH_E && info_mode)
                    state_next = arp_pkg::S_ERR_R1;
                else if (rx_byte == arp_pkg::CH_O && info_mode)
                    state_next = arp_pkg::S_OK_K;
                else if (is_raw && !info_mode)
                begin
                    state_next = arp_pkg::S_RAW;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_OK_K:
            begin
                if (rx_byte == arp_pkg::CH_K)
                begin
                    state_next = arp_pkg::S_FIN_CR;
                    ok_next    = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_FIN_CR:
            begin
                if (rx_byte == arp_pkg::CH_CR) state_next = arp_pkg::S_FIN_LF;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_FIN_LF:
            begin
                if (rx_byte == arp_pkg::CH_LF)
                begin
                    state_next = arp_pkg::S_WAIT_CR;
                    status     = arp_pkg::ST_DONE;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_ERR_R1:
            begin
                if (rx_byte == arp_pkg::CH_R) state_next = arp_pkg::S_ERR_R2;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_ERR_R2:
            begin
                if (rx_byte == arp_pkg::CH_R) state_next = arp_pkg::S_ERR_O;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_ERR_O:
            begin
                if (rx_byte == arp_pkg::CH_O) state_next = arp_pkg::S_ERR_R3;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_ERR_R3:
            begin
                if (rx_byte == arp_pkg::CH_R)
                begin
                    state_next = arp_pkg::S_FIN_CR;
                    ok_next    = 1'b0;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_FINAL, arp_pkg::S_RAW_FINAL:
            begin
                if (rx_byte == arp_pkg::CH_E) state_next = arp_pkg::S_ERR_R1;
                else if (rx_byte == arp_pkg::CH_O) state_next = arp_pkg::S_OK_K;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_NAME1:
            begin
                if (is_upper)
                begin
                    state_next = arp_pkg::S_NAME;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_NAME:
            begin
                if (is_upper)
                    do_put = 1'b1;
                else if (rx_byte == arp_pkg::CH_COLON)
                begin
                    state_next = arp_pkg::S_SPACE;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_SPACE:
            begin
                if (rx_byte == arp_pkg::CH_SPACE)
                begin
                    state_next = arp_pkg::S_TEXT1;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_TEXT1:
            begin
                if (is_print)
                begin
                    state_next = arp_pkg::S_TEXT;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_TEXT:
            begin
                if (is_print)
                    do_put = 1'b1;
                else if (rx_byte == arp_pkg::CH_CR)
                begin
                    state_next = arp_pkg::S_INFO_LF;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_INFO_LF:
            begin
                if (rx_byte == arp_pkg::CH_LF)
                begin
                    state_next = arp_pkg::S_NEXT;
                    do_end     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_NEXT:
            begin
                if (rx_byte == arp_pkg::CH_CR)
                    state_next = arp_pkg::S_BLANK_LF;
                else if (rx_byte == arp_pkg::CH_PLUS)
                begin
                    state_next = arp_pkg::S_NAME1;
                    do_plus    = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_BLANK_LF:
            begin
                if (rx_byte == arp_pkg::CH_LF) state_next = arp_pkg::S_FINAL;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_RAW:
            begin
                if (is_raw)
                    do_put = 1'b1;
                else if (rx_byte == arp_pkg::CH_CR)
                begin
                    state_next = arp_pkg::S_RAW_LF;
                    do_put     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_RAW_LF:
            begin
                if (rx_byte == arp_pkg::CH_LF)
                begin
                    state_next = arp_pkg::S_RAW_CR2;
                    do_end     = 1'b1;
                end
                else
                    status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_RAW_CR2:
            begin
                if (rx_byte == arp_pkg::CH_CR) state_next = arp_pkg::S_RAW_LF2;
                else status = arp_pkg::ST_SYNTAX;
            end
            arp_pkg::S_RAW_LF2:
            begin
                if (rx_byte == arp_pkg::CH_LF) state_next = arp_pkg::S_RAW_FINAL;
                else status = arp_pkg::ST_SYNTAX;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        // store position update; the line terminator zero reads back as an unwritten byte
        wr.we    = 1'b0;
        wr.clear = 1'b0;
        wr.row   = line_reg[arp_pkg::ROW_W-1:0];
        wr.col   = col_reg[arp_pkg::COL_W-1:0];
        wr.data  = rx_byte;
        if (room && (do_put || do_end || do_plus))
        begin
            wr.we = step;
        end
        if (room && do_put)
        begin
            col_next = col_reg + arp_pkg::COLIDX_W'(1);
        end
        if (room && do_end)
        begin
            line_next = line_reg + arp_pkg::LINE_W'(1);
            col_next  = '0;
        end
        if (room && do_plus)
        begin
            wr.col   = '0;
            col_next = arp_pkg::COLIDX_W'(1);
        end
        if (do_clear)
        begin
            ok_next   = 1'b0;
            line_next = '0;
            col_next  = '0;
            wr.clear  = step;
        end

        // values seen by this beat
        view.status  = status;
        view.ok_mark = ok_next;
        view.lines   = line_next;
    end

endmodule

/* rtl/arp_text_store.sv */
// ----------------------------------------------------------------------------
// arp_text_store
// Line text memory with per-row fill counts and write-to-read forwarding.
// ----------------------------------------------------------------------------
module arp_text_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  arp_pkg::arp_wr_t           wr,
    input  logic                       load,
    input  logic [arp_pkg::ROW_W-1:0]  load_row,
    input  logic [arp_pkg::COL_W-1:0]  load_col,
    input  logic [arp_pkg::ROW_W-1:0]  cur_row,
    input  logic [arp_pkg::COL_W-1:0]  cur_col,
    output logic [arp_pkg::BYTE_W-1:0] rd_byte
);

    logic [arp_pkg::COLIDX_W-1:0] fill_reg [arp_pkg::MAX_LINES];
    logic                         fwd_hit_reg;
    logic [arp_pkg::BYTE_W-1:0]   fwd_data_reg;
    logic [arp_pkg::BYTE_W-1:0]   ram_data;
    logic [arp_pkg::ADDR_W-1:0]   wr_addr;
    logic [arp_pkg::ADDR_W-1:0]   rd_addr;

    assign wr_addr = {wr.row, wr.col};
    assign rd_addr = {load_row, load_col};

    arp_ram #(
        .WIDTH (arp_pkg::BYTE_W),
        .DEPTH (arp_pkg::STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.we),
        .wr_addr (wr_addr),
        .wr_data (wr.data),
        .rd_en   (load),
        .rd_addr (rd_addr),
        .rd_data (ram_data)
    );

    // bytes written per row in the current response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < arp_pkg::MAX_LINES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (wr.clear)
        begin
            for (int i = 0; i < arp_pkg::MAX_LINES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            fill_reg[wr.row] <= {1'b0, wr.col} + arp_pkg::COLIDX_W'(1);
        end
    end

    // catch a write landing on the same edge as the read sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (load)
        begin
            fwd_hit_reg <= wr.we && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fwd_data_reg <= wr.data;
        end
    end

    // unwritten positions read as zero
    always_comb
    begin
        if ({1'b0, cur_col} >= fill_reg[cur_row])
            rd_byte = '0;
        else if (fwd_hit_reg)
            rd_byte = fwd_data_reg;
        else
            rd_byte = ram_data;
    end

endmodule

/* rtl/at_response_parser.sv */
// ----------------------------------------------------------------------------
// at_response_parser
// Byte-wise AT command response parser with a line text store.
// ----------------------------------------------------------------------------
// path: input beat to result beat through the input register, then the result register
// throughput: one beat per cycle while out_ready holds, set by the single store write and read port
// reset: rst_n clears parser state, line counts and handshake state at once;
// the text store needs no sweep, per-row fill counts mark it empty
module at_response_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       response_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic [2:0] read_row,
    input  logic [5:0] read_col,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       final_was_ok,
    output logic [3:0] lines_stored,
    output logic [7:0] read_data
);

    logic                       mode_reg;
    logic                       s1_valid_reg;
    logic                       s1_action_reg;
    logic [7:0]                 s1_byte_reg;
    logic [arp_pkg::ROW_W-1:0]  s1_row_reg;
    logic [arp_pkg::COL_W-1:0]  s1_col_reg;
    logic                       out_valid_reg;
    logic [1:0]                 status_reg;
    logic                       ok_reg;
    logic [3:0]                 lines_reg;
    logic [7:0]                 data_reg;
    logic                       advance;
    logic                       accept;
    logic                       feed_step;
    arp_pkg::arp_view_t         view;
    arp_pkg::arp_wr_t           wr;
    logic [7:0]                 rd_byte;

    // handshake
    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign feed_step = advance && (s1_action_reg == arp_pkg::ACT_FEED);

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= arp_pkg::MODE_INFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= response_mode;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= rx_byte;
            s1_row_reg    <= read_row;
            s1_col_reg    <= read_col;
        end
    end

    arp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (feed_step),
        .rx_byte (s1_byte_reg),
        .mode    (mode_reg),
        .view    (view),
        .wr      (wr)
    );

    arp_text_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .load     (accept),
        .load_row (read_row),
        .load_col (read_col),
        .cur_row  (s1_row_reg),
        .cur_col  (s1_col_reg),
        .rd_byte  (rd_byte)
    );

    // result register; a read beat leaves the parser untouched, so the
    // mark and line count from the last fed byte still hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            lines_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (feed_step)
            begin
                ok_reg    <= view.ok_mark;
                lines_reg <= view.lines;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_action_reg == arp_pkg::ACT_READ)
            begin
                status_reg <= arp_pkg::ST_BUSY;
                data_reg   <= rd_byte;
            end
            else
            begin
                status_reg <= view.status;
                data_reg   <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign final_was_ok = ok_reg;
    assign lines_stored = lines_reg;
    assign read_data    = data_reg;

endmodule

/* bench/at_response_checker.sv */
// ----------------------------------------------------------------------------
// at_response_checker
// Watches the config, input and result channels of the AT response parser.
// Keeps its own copy of the parser state and text store, works out the
// result of every accepted input beat and compares it field by field with
// the result beats, oldest first.
// ----------------------------------------------------------------------------
module at_response_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       response_mode,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic [2:0] read_row,
    input  logic [5:0] read_col,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status,
    input  logic       final_was_ok,
    input  logic [3:0] lines_stored,
    input  logic [7:0] read_data,
    output int         mismatch_count,
    output int         results_due
);

    // one predicted result beat
    typedef struct packed {
        arp_pkg::arp_status_t       status;
        logic                       ok;
        logic [arp_pkg::LINE_W-1:0] lines;
        logic [arp_pkg::BYTE_W-1:0] data;
    } parser_result_t;

    // predicted parser state
    arp_pkg::arp_state_t          pstate;
    logic                         mode_q;
    logic                         ok_flag;
    logic [arp_pkg::LINE_W-1:0]   line_cnt;
    logic [arp_pkg::COLIDX_W-1:0] col_pos;
    logic [arp_pkg::BYTE_W-1:0]   text_mem [arp_pkg::STORE_DEPTH];
    parser_result_t               expected_results [$];
    int                           errors = 0;

    function automatic logic has_room();
        return (col_pos < arp_pkg::LINE_SIZE) && (line_cnt < arp_pkg::MAX_LINES);
    endfunction

    // character write, dropped when the store position is out of range
    function automatic void store_char(logic [7:0] c);
        if (has_room())
        begin
            text_mem[line_cnt * arp_pkg::LINE_SIZE + col_pos] = c;
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // LF plus terminating zero; line advances only if the LF fit
    function automatic void close_line(logic [7:0] c);
        if (has_room())
        begin
            store_char(c);
            store_char(8'h00);
            line_cnt = line_cnt + 1'b1;
            col_pos  = '0;
        end
    endfunction

    function automatic void clear_text();
        ok_flag  = 1'b0;
        line_cnt = '0;
        col_pos  = '0;
        foreach (text_mem[i]) text_mem[i] = '0;
    endfunction

    // parse one received byte; a syntax error leaves every state bit alone
    function automatic arp_pkg::arp_status_t feed_byte(logic [7:0] c);
        logic                 info, upper, print, raw;
        arp_pkg::arp_status_t rs;
        info  = (mode_q == arp_pkg::MODE_INFO);
        upper = (c >= arp_pkg::UPPER_LO) && (c <= arp_pkg::UPPER_HI);
        print = (c >= arp_pkg::PRINT_LO) && (c <= arp_pkg::PRINT_HI);
        raw   = (c >= arp_pkg::RAW_LO) && (c <= arp_pkg::RAW_HI);
        rs    = arp_pkg::ST_BUSY;
        case (pstate)
            arp_pkg::S_WAIT_CR:
                if (c == arp_pkg::CH_CR)
                begin
                    pstate = arp_pkg::S_LF;
                    clear_text();
                end
            arp_pkg::S_LF:
                if (c == arp_pkg::CH_LF) pstate = arp_pkg::S_START;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_START:
                if (c == arp_pkg::CH_PLUS && info)
                begin
                    pstate = arp_pkg::S_NAME1;
                    store_char(c);
                end
                else if (c == arp_pkg::CH_E && info) pstate = arp_pkg::S_ERR_R1;
                else if (c == arp_pkg::CH_O && info) pstate = arp_pkg::S_OK_K;
                else if (raw && !info)
                begin
                    pstate = arp_pkg::S_RAW;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_OK_K:
                if (c == arp_pkg::CH_K)
                begin
                    pstate  = arp_pkg::S_FIN_CR;
                    ok_flag = 1'b1;
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_FIN_CR:
                if (c == arp_pkg::CH_CR) pstate = arp_pkg::S_FIN_LF;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_FIN_LF:
                if (c == arp_pkg::CH_LF)
                begin
                    pstate = arp_pkg::S_WAIT_CR;
                    rs     = arp_pkg::ST_DONE;
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_ERR_R1:
                if (c == arp_pkg::CH_R) pstate = arp_pkg::S_ERR_R2;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_ERR_R2:
                if (c == arp_pkg::CH_R) pstate = arp_pkg::S_ERR_O;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_ERR_O:
                if (c == arp_pkg::CH_O) pstate = arp_pkg::S_ERR_R3;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_ERR_R3:
                if (c == arp_pkg::CH_R)
                begin
                    pstate  = arp_pkg::S_FIN_CR;
                    ok_flag = 1'b0;
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_FINAL, arp_pkg::S_RAW_FINAL:
                if (c == arp_pkg::CH_E) pstate = arp_pkg::S_ERR_R1;
                else if (c == arp_pkg::CH_O) pstate = arp_pkg::S_OK_K;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_NAME1:
                if (upper)
                begin
                    pstate = arp_pkg::S_NAME;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_NAME:
                if (upper) store_char(c);
                else if (c == arp_pkg::CH_COLON)
                begin
                    pstate = arp_pkg::S_SPACE;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_SPACE:
                if (c == arp_pkg::CH_SPACE)
                begin
                    pstate = arp_pkg::S_TEXT1;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_TEXT1:
                if (print)
                begin
                    pstate = arp_pkg::S_TEXT;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_TEXT:
                if (print) store_char(c);
                else if (c == arp_pkg::CH_CR)
                begin
                    pstate = arp_pkg::S_INFO_LF;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_INFO_LF:
                if (c == arp_pkg::CH_LF)
                begin
                    pstate = arp_pkg::S_NEXT;
                    close_line(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_NEXT:
                if (c == arp_pkg::CH_CR) pstate = arp_pkg::S_BLANK_LF;
                else if (c == arp_pkg::CH_PLUS)
                begin
                    pstate = arp_pkg::S_NAME1;
                    if (has_room())
                    begin
                        col_pos = '0;
                        store_char(c);
                    end
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_BLANK_LF:
                if (c == arp_pkg::CH_LF) pstate = arp_pkg::S_FINAL;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_RAW:
                if (raw) store_char(c);
                else if (c == arp_pkg::CH_CR)
                begin
                    pstate = arp_pkg::S_RAW_LF;
                    store_char(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_RAW_LF:
                if (c == arp_pkg::CH_LF)
                begin
                    pstate = arp_pkg::S_RAW_CR2;
                    close_line(c);
                end
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_RAW_CR2:
                if (c == arp_pkg::CH_CR) pstate = arp_pkg::S_RAW_LF2;
                else rs = arp_pkg::ST_SYNTAX;
            arp_pkg::S_RAW_LF2:
                if (c == arp_pkg::CH_LF) pstate = arp_pkg::S_RAW_FINAL;
                else rs = arp_pkg::ST_SYNTAX;
            default: ;
        endcase
        return rs;
    endfunction

    // result of one input beat
    function automatic parser_result_t predict_beat(logic act, logic [7:0] c,
                                                    logic [2:0] row, logic [5:0] col);
        parser_result_t r;
        r.status = arp_pkg::ST_BUSY;
        r.data   = '0;
        if (act == arp_pkg::ACT_FEED) r.status = feed_byte(c);
        else r.data = text_mem[row * arp_pkg::LINE_SIZE + col];
        r.ok    = ok_flag;
        r.lines = line_cnt;
        return r;
    endfunction

    // channel monitor: config, then input, then result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        parser_result_t want;
        if (!rst_n)
        begin
            pstate = arp_pkg::S_WAIT_CR;
            mode_q = arp_pkg::MODE_INFO;
            clear_text();
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) mode_q = response_mode;
            if (in_valid && in_ready)
                expected_results.push_back(predict_beat(action, rx_byte, read_row, read_col));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || final_was_ok !== want.ok ||
                        lines_stored !== want.lines || read_data !== want.data)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "%0t: exp/act status %0d/%0d ok %0d/%0d lines %0d/%0d data %h/%h",
                                $time, want.status, status, want.ok, final_was_ok,
                                want.lines, lines_stored, want.data, read_data);
                    end
                end
            end
        end
        mismatch_count <= errors;
        results_due    <= expected_results.size();
    end

endmodule

/* bench/tb_at_response_parser.sv */
// ----------------------------------------------------------------------------
// tb_at_response_parser
// Drives AT responses, both well formed and damaged, plus text store reads
// into the parser in both response modes, with bursty input and a stalling
// receiver. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_at_response_parser;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;
    localparam int CYCLE_LIMIT = 400000;

    // one input beat
    typedef struct packed {
        logic                      act;
        logic [7:0]                rx;
        logic [arp_pkg::ROW_W-1:0] row;
        logic [arp_pkg::COL_W-1:0] col;
    } rx_item_t;

    typedef enum int {DMG_NONE, DMG_OVERWRITE, DMG_DROP, DMG_TRUNCATE} damage_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       response_mode;
    logic       in_valid;
    logic       in_ready;
    logic       action;
    logic [7:0] rx_byte;
    logic [2:0] read_row;
    logic [5:0] read_col;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic       final_was_ok;
    logic [3:0] lines_stored;
    logic [7:0] read_data;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;
    int stall_style = 0;
    int style_left  = 0;

    rx_item_t beat_q [$];
    rx_item_t resp_q [$];

    at_response_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .response_mode(response_mode),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .rx_byte      (rx_byte),
        .read_row     (read_row),
        .read_col     (read_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .final_was_ok (final_was_ok),
        .lines_stored (lines_stored),
        .read_data    (read_data)
    );

    at_response_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .response_mode (response_mode),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .rx_byte       (rx_byte),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .final_was_ok  (final_was_ok),
        .lines_stored  (lines_stored),
        .read_data     (read_data),
        .mismatch_count(mismatch_count),
        .results_due   (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("at_response_parser regression: fail");
            $finish;
        end
    end

    // receiver backpressure, switching between stall styles
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(16, 160);
        end
        else style_left <= style_left - 1;
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycle_count % 4 == 0);
            default: out_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    function automatic void push_feed(logic [7:0] b);
        rx_item_t it;
        it = '{act: arp_pkg::ACT_FEED, rx: b, row: '0, col: '0};
        resp_q.push_back(it);
    endfunction

    function automatic rx_item_t make_read(logic [2:0] row, logic [5:0] col);
        rx_item_t it;
        it = '{act: arp_pkg::ACT_READ, rx: 8'($urandom_range(0, 255)), row: row, col: col};
        return it;
    endfunction

    // reads lean toward the rows and columns that usually hold text
    function automatic rx_item_t random_read();
        logic [2:0] row;
        logic [5:0] col;
        row = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2));
        col = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 15));
        return make_read(row, col);
    endfunction

    function automatic void gen_final_word();
        if ($urandom_range(0, 1))
        begin
            push_feed(arp_pkg::CH_O);
            push_feed(arp_pkg::CH_K);
        end
        else
        begin
            push_feed(arp_pkg::CH_E);
            push_feed(arp_pkg::CH_R);
            push_feed(arp_pkg::CH_R);
            push_feed(arp_pkg::CH_O);
            push_feed(arp_pkg::CH_R);
        end
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
    endfunction

    // mode 0: plus-prefixed info lines, sometimes enough to overflow the store
    function automatic void gen_info_response();
        int nlines, nlen, tlen;
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        nlines = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 3);
        for (int i = 0; i < nlines; i++)
        begin
            push_feed(arp_pkg::CH_PLUS);
            nlen = $urandom_range(1, 5);
            for (int k = 0; k < nlen; k++)
                push_feed(8'($urandom_range(arp_pkg::UPPER_LO, arp_pkg::UPPER_HI)));
            push_feed(arp_pkg::CH_COLON);
            push_feed(arp_pkg::CH_SPACE);
            tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 8);
            for (int k = 0; k < tlen; k++)
                push_feed(8'($urandom_range(arp_pkg::PRINT_LO, arp_pkg::PRINT_HI)));
            push_feed(arp_pkg::CH_CR);
            push_feed(arp_pkg::CH_LF);
        end
        if (nlines > 0)
        begin
            push_feed(arp_pkg::CH_CR);
            push_feed(arp_pkg::CH_LF);
        end
        gen_final_word();
    endfunction

    // mode 1: one raw data line, sometimes longer than a store row
    function automatic void gen_raw_response();
        int len;
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
            push_feed(8'($urandom_range(arp_pkg::RAW_LO, arp_pkg::RAW_HI)));
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        gen_final_word();
    endfunction

    // damage the staged response if asked, then move it to the send queue
    function automatic void commit(damage_t dmg);
        int pos;
        if (resp_q.size() > 1)
        begin
            pos = $urandom_range(0, resp_q.size() - 1);
            case (dmg)
                DMG_OVERWRITE: resp_q[pos].rx = 8'($urandom_range(0, 255));
                DMG_DROP:      resp_q.delete(pos);
                DMG_TRUNCATE:  resp_q = resp_q[0:pos];
                default: ;
            endcase
        end
        foreach (resp_q[i]) beat_q.push_back(resp_q[i]);
        resp_q.delete();
    endfunction

    function automatic damage_t pick_damage();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return DMG_NONE;
        if (r < 85) return DMG_OVERWRITE;
        if (r < 92) return DMG_DROP;
        return DMG_TRUNCATE;
    endfunction

    // hold input off until every expected result beat is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid     <= 1'b1;
        response_mode <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // send the queue in bursts with random gaps and the odd full pause
    task automatic send_queued();
        int       burst, gap;
        rx_item_t it;
        while (beat_q.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && beat_q.size() > 0)
            begin
                it = beat_q.pop_front();
                in_valid <= 1'b1;
                action   <= it.act;
                rx_byte  <= it.rx;
                read_row <= it.row;
                read_col <= it.col;
                do @(posedge clk); while (!in_ready);
                burst--;
            end
            if ($urandom_range(0, 39) == 0) drain();
            else if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        logic phase_mode;
        int   pick, n;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        response_mode <= arp_pkg::MODE_INFO;
        in_valid      <= 1'b0;
        action        <= arp_pkg::ACT_FEED;
        rx_byte       <= '0;
        read_row      <= '0;
        read_col      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(arp_pkg::MODE_INFO);

        // directed: ignored bytes, syntax error, one info line, ERROR, reads
        push_feed(8'h00);
        push_feed(8'hFF);
        push_feed(arp_pkg::CH_CR);
        push_feed(8'hFF);
        push_feed(arp_pkg::CH_LF);
        push_feed(arp_pkg::CH_PLUS);
        push_feed(arp_pkg::CH_E);
        push_feed(arp_pkg::CH_COLON);
        push_feed(arp_pkg::CH_SPACE);
        push_feed(arp_pkg::PRINT_HI);
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        resp_q.push_back(make_read(3'd0, 6'd4));
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        push_feed(arp_pkg::CH_E);
        push_feed(arp_pkg::CH_R);
        push_feed(arp_pkg::CH_R);
        push_feed(arp_pkg::CH_O);
        push_feed(arp_pkg::CH_R);
        push_feed(arp_pkg::CH_CR);
        push_feed(arp_pkg::CH_LF);
        resp_q.push_back(make_read(3'd0, 6'd0));
        resp_q.push_back(make_read(3'd0, 6'd63));
        resp_q.push_back(make_read(3'd7, 6'd63));
        commit(DMG_NONE);
        send_queued();
        drain();

        // random phases, raw mode first, then info mode, then either
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0) phase_mode = arp_pkg::MODE_RAW;
            else if (p == 1) phase_mode = arp_pkg::MODE_INFO;
            else phase_mode = 1'($urandom_range(0, 1));
            repeat (3) @(posedge clk);
            write_mode(phase_mode);
            while (beat_q.size() < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    if (phase_mode == arp_pkg::MODE_INFO) gen_info_response();
                    else gen_raw_response();
                    if ($urandom_range(0, 2) == 0)
                        resp_q.insert($urandom_range(0, resp_q.size()), random_read());
                    commit(pick_damage());
                end
                else if (pick < 88)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) resp_q.push_back(random_read());
                    commit(DMG_NONE);
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_feed(8'($urandom_range(0, 255)));
                    commit(DMG_NONE);
                end
            end
            send_queued();
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("at_response_parser regression: pass");
        else
            $display("at_response_parser regression: fail");
        $finish;
    end

endmodule
